// ===== hdl/oll_pkg.sv =====
// Shared types and constants for the object line loader.
// No dependencies; every other file in hdl/ refers to this package by scoped name.
`timescale 1ns / 1ps

package oll_pkg;

  localparam int MEM_SIZE_DEFAULT = 4096;
  localparam int MAX_BYTES        = 10;
  localparam int QUEUE_DEPTH      = 2;

  // item kinds on the input channel
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_EOL  = 2'd1;
  localparam logic [1:0] KIND_EOF  = 2'd2;

  // result kinds
  localparam logic [2:0] RES_BYTE      = 3'd0;
  localparam logic [2:0] RES_ACCEPT    = 3'd1;
  localparam logic [2:0] RES_REJECT    = 3'd2;
  localparam logic [2:0] RES_LOAD_OK   = 3'd3;
  localparam logic [2:0] RES_LOAD_FAIL = 3'd4;

  // column layout of a line
  localparam logic [4:0] COL_FIRST     = 5'd0;
  localparam logic [4:0] COL_X         = 5'd1;
  localparam logic [4:0] COL_ADDR_LAST = 5'd4;
  localparam logic [4:0] COL_COLON     = 5'd5;
  localparam logic [4:0] COL_GAP       = 5'd6;
  localparam logic [4:0] COL_DATA      = 5'd7;
  localparam logic [4:0] COL_BAR       = 5'd28;

  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [11:0] address;
    logic [7:0]  data_byte;
    logic [15:0] line_number;
    logic        last;
  } out_item_t;

  // one finished line (and/or end of file) handed from front to back
  typedef struct packed {
    logic [3:0]                  nbytes;
    logic [11:0]                 base;
    logic [MAX_BYTES-1:0][7:0]   bytes;
    logic                        line_res_en;
    logic [2:0]                  line_res;
    logic                        eof_res_en;
    logic [2:0]                  eof_res;
    logic [15:0]                 line_num;
    logic [15:0]                 eof_num;
  } job_t;

endpackage

// ===== hdl/oll_front.sv =====
// Front end: parses characters into line state and classifies each line end.
// Uses oll_pkg; pushes one job_t per file end, and per finished line while the load has not failed, into the queue.
`timescale 1ns / 1ps

module oll_front #(
  parameter int MEM_SIZE = oll_pkg::MEM_SIZE_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  oll_pkg::in_item_t  in_item,
  input  logic               q_full,
  output logic               q_push,
  output oll_pkg::job_t      q_job
);

  localparam logic [12:0] MEM_LIMIT = 13'(MEM_SIZE);

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]})      r = {1'b1, 4'(c - 8'h30)};
    else if (c inside {[8'h61:8'h66]}) r = {1'b1, 4'(c - 8'h57)};
    else if (c inside {[8'h41:8'h46]}) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  logic [4:0]  column_r, column_nxt;
  logic        line_bad_r, line_bad_nxt;
  logic        has_address_r, has_address_nxt;
  logic        has_data_r, has_data_nxt;
  logic        data_ended_r, data_ended_nxt;
  logic [11:0] line_address_r, line_address_nxt;
  logic [4:0]  digit_count_r, digit_count_nxt;
  logic [3:0]  high_nibble_r, high_nibble_nxt;
  logic [12:0] next_address_r, next_address_nxt;
  logic        load_failed_r, load_failed_nxt;
  logic [15:0] line_count_r, line_count_nxt;
  logic [7:0]  byte_buffer_r [oll_pkg::MAX_BYTES];

  logic        buf_we;
  logic [3:0]  buf_idx;
  logic [7:0]  buf_val;

  logic        accept;
  logic [7:0]  ch;
  logic [4:0]  hex;
  logic [3:0]  nbytes;
  logic [12:0] line_end;
  logic        bad;
  logic [15:0] line_count_inc;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign ch       = in_item.char_code;
  assign hex      = hex_decode(ch);
  assign nbytes   = digit_count_r[4:1];
  assign line_end = {1'b0, line_address_r} + 13'(nbytes);
  assign line_count_inc = (line_count_r != 16'hFFFF) ? line_count_r + 16'd1 : line_count_r;

  always_comb begin
    bad = line_bad_r || (column_r <= oll_pkg::COL_BAR);
    if (!bad && has_data_r) begin
      if (digit_count_r[0] || (nbytes > 4'(oll_pkg::MAX_BYTES))) bad = 1'b1;
      else if ({1'b0, line_address_r} < next_address_r) bad = 1'b1;
      else if (line_end > MEM_LIMIT) bad = 1'b1;
    end
  end

  always_comb begin
    column_nxt       = column_r;
    line_bad_nxt     = line_bad_r;
    has_address_nxt  = has_address_r;
    has_data_nxt     = has_data_r;
    data_ended_nxt   = data_ended_r;
    line_address_nxt = line_address_r;
    digit_count_nxt  = digit_count_r;
    high_nibble_nxt  = high_nibble_r;
    next_address_nxt = next_address_r;
    load_failed_nxt  = load_failed_r;
    line_count_nxt   = line_count_r;
    buf_we  = 1'b0;
    buf_idx = digit_count_r[4:1];
    buf_val = {high_nibble_r, hex[3:0]};
    q_push  = 1'b0;
    q_job   = '0;
    q_job.base     = line_address_r;
    q_job.line_num = line_count_r;
    for (int i = 0; i < oll_pkg::MAX_BYTES; i++) q_job.bytes[i] = byte_buffer_r[i];

    if (accept) begin
      case (in_item.kind)
        oll_pkg::KIND_CHAR: begin
          if (!load_failed_r && column_r <= oll_pkg::COL_BAR) begin
            column_nxt = column_r + 5'd1;
            if (!line_bad_r) begin
              if (column_r == oll_pkg::COL_BAR) begin
                if (ch != oll_pkg::CH_BAR || (has_data_r && !data_ended_r)) line_bad_nxt = 1'b1;
              end else if (column_r == oll_pkg::COL_FIRST) begin
                if (ch == oll_pkg::CH_ZERO) has_address_nxt = 1'b1;
                else if (ch != oll_pkg::CH_SPACE) line_bad_nxt = 1'b1;
              end else if (!has_address_r) begin
                if (ch != oll_pkg::CH_SPACE) line_bad_nxt = 1'b1;
              end else if (column_r == oll_pkg::COL_X) begin
                if (ch != oll_pkg::CH_X) line_bad_nxt = 1'b1;
              end else if (column_r <= oll_pkg::COL_ADDR_LAST) begin
                if (!hex[4]) line_bad_nxt = 1'b1;
                else line_address_nxt = {line_address_r[7:0], hex[3:0]};
              end else if (column_r == oll_pkg::COL_COLON) begin
                if (ch != oll_pkg::CH_COLON) line_bad_nxt = 1'b1;
              end else if (column_r == oll_pkg::COL_GAP) begin
                if (ch != oll_pkg::CH_SPACE) line_bad_nxt = 1'b1;
              end else if (column_r == oll_pkg::COL_DATA && ch == oll_pkg::CH_SPACE) begin
                data_ended_nxt = 1'b1;
              end else begin
                if (column_r == oll_pkg::COL_DATA) has_data_nxt = 1'b1;
                if (data_ended_r) begin
                  if (ch != oll_pkg::CH_SPACE) line_bad_nxt = 1'b1;
                end else if (ch == oll_pkg::CH_SPACE) begin
                  data_ended_nxt = 1'b1;
                  if (digit_count_r[0]) line_bad_nxt = 1'b1;
                end else if (!hex[4]) begin
                  line_bad_nxt = 1'b1;
                end else begin
                  digit_count_nxt = digit_count_r + 5'd1;
                  if (!digit_count_r[0]) high_nibble_nxt = hex[3:0];
                  else if (digit_count_r[4:1] < 4'(oll_pkg::MAX_BYTES)) buf_we = 1'b1;
                end
              end
            end
          end
        end

        oll_pkg::KIND_EOL, oll_pkg::KIND_EOF: begin
          // line-level outcome, shared by end of line and a pending line at end of file
          if (!load_failed_r && (in_item.kind == oll_pkg::KIND_EOL ||
                                 column_r != oll_pkg::COL_FIRST)) begin
            if (bad) begin
              q_job.line_res_en = 1'b1;
              q_job.line_res    = oll_pkg::RES_REJECT;
              load_failed_nxt   = 1'b1;
            end else begin
              if (has_data_r) begin
                q_job.nbytes     = nbytes;
                next_address_nxt = line_end;
              end
              q_job.line_res_en = (in_item.kind == oll_pkg::KIND_EOL);
              q_job.line_res    = oll_pkg::RES_ACCEPT;
              line_count_nxt    = line_count_inc;
            end
          end
          if (in_item.kind == oll_pkg::KIND_EOL) begin
            q_push = !load_failed_r;
          end else begin
            q_push           = 1'b1;
            q_job.eof_res_en = 1'b1;
            q_job.eof_res    = load_failed_nxt ? oll_pkg::RES_LOAD_FAIL : oll_pkg::RES_LOAD_OK;
            q_job.eof_num    = line_count_nxt;
            next_address_nxt = '0;
            load_failed_nxt  = 1'b0;
            line_count_nxt   = 16'd1;
          end
          column_nxt       = '0;
          line_bad_nxt     = 1'b0;
          has_address_nxt  = 1'b0;
          has_data_nxt     = 1'b0;
          data_ended_nxt   = 1'b0;
          line_address_nxt = '0;
          digit_count_nxt  = '0;
          high_nibble_nxt  = '0;
        end

        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r       <= '0;
      line_bad_r     <= 1'b0;
      has_address_r  <= 1'b0;
      has_data_r     <= 1'b0;
      data_ended_r   <= 1'b0;
      line_address_r <= '0;
      digit_count_r  <= '0;
      high_nibble_r  <= '0;
      next_address_r <= '0;
      load_failed_r  <= 1'b0;
      line_count_r   <= 16'd1;
    end else begin
      column_r       <= column_nxt;
      line_bad_r     <= line_bad_nxt;
      has_address_r  <= has_address_nxt;
      has_data_r     <= has_data_nxt;
      data_ended_r   <= data_ended_nxt;
      line_address_r <= line_address_nxt;
      digit_count_r  <= digit_count_nxt;
      high_nibble_r  <= high_nibble_nxt;
      next_address_r <= next_address_nxt;
      load_failed_r  <= load_failed_nxt;
      line_count_r   <= line_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) byte_buffer_r[buf_idx] <= buf_val;
  end

endmodule

// ===== hdl/oll_queue.sv =====
// Short job queue between the front end and the result sequencer.
// Uses oll_pkg for job_t and the depth.
`timescale 1ns / 1ps

module oll_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  oll_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output oll_pkg::job_t head_job
);

  localparam int DEPTH = oll_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  oll_pkg::job_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    if (do_push && !do_pop)      count_nxt = count_r + CNT_W'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

endmodule

// ===== hdl/oll_back.sv =====
// Back end: steps through the head job and emits its results one per cycle while out_stall is low.
// Uses oll_pkg; drives the registered output channel.
`timescale 1ns / 1ps

module oll_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  oll_pkg::job_t      head_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output oll_pkg::out_item_t out_item
);

  logic [3:0]         step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  oll_pkg::out_item_t out_item_r, out_item_nxt;
  logic [3:0]         total;
  logic               emit;
  logic               is_last;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign total   = head_job.nbytes + 4'(head_job.line_res_en) + 4'(head_job.eof_res_en);
  assign emit    = head_valid && (!out_valid_r || !out_stall);
  assign is_last = (step_r + 4'd1 == total);
  assign pop     = emit && is_last;

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = '0;
      out_item_nxt.last = is_last;
      if (step_r < head_job.nbytes) begin
        out_item_nxt.result_kind = oll_pkg::RES_BYTE;
        out_item_nxt.address     = head_job.base + 12'(step_r);
        out_item_nxt.data_byte   = head_job.bytes[step_r];
        out_item_nxt.line_number = head_job.line_num;
      end else if (step_r == head_job.nbytes && head_job.line_res_en) begin
        out_item_nxt.result_kind = head_job.line_res;
        out_item_nxt.line_number = head_job.line_num;
      end else begin
        out_item_nxt.result_kind = head_job.eof_res;
        out_item_nxt.line_number = head_job.eof_num;
      end
      step_nxt = is_last ? 4'd0 : step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule

// ===== hdl/object_line_loader.sv =====
// Top level of the object line loader: front end, job queue, result sequencer.
// Depends on oll_pkg, oll_front, oll_queue and oll_back.
//
//   channel   ports                          payload
//   input     in_valid / in_stall / in_item   in_item_t  (kind, char_code)
//   output    out_valid / out_stall / out_item out_item_t (result_kind .. last)
//
// One input transaction per cycle while the queue has room.
// An end of file, or an end of line while the load has not failed, becomes a
// queued job; the sequencer emits its results at one per cycle while out_stall
// is low (byte count plus one, or two for a line rejected at end of file).
// in_stall rises only while the two-entry queue is full, and then holds every
// transaction, characters included. Reset is synchronous, with no clearing pass.
`timescale 1ns / 1ps

module object_line_loader #(
  parameter int MEM_SIZE = oll_pkg::MEM_SIZE_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  oll_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output oll_pkg::out_item_t out_item
);

  logic          q_full, q_push, q_pop, head_valid;
  oll_pkg::job_t q_job, head_job;

  oll_front #(
    .MEM_SIZE (MEM_SIZE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  oll_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  oll_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for object_line_loader: directed lines from a table, then random
// lines, with random idling on both channels. Depends on hdl/oll_pkg.sv and the loader RTL.
`timescale 1ns / 1ps

module tb_top;
  import oll_pkg::*;

  localparam int LOAD_MEM_SIZE = MEM_SIZE_DEFAULT;
  localparam int ITEM_TARGET = 230;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [2:0] RES_NONE = 3'd7;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef enum int {FRAME_NONE, FRAME_PAD, FRAME_BAR} frame_t;

  typedef struct {
    string body;
    frame_t frame;
    string note;
    logic [1:0] term;
    bit typed;
    logic [2:0] want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  object_line_loader #(.MEM_SIZE(LOAD_MEM_SIZE)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  always #2 clk = ~clk;

  // loader state as predicted
  int scan_col;
  bit line_broken;
  bit addr_seen;
  bit data_seen;
  bit data_done;
  int line_base;
  int digit_total;
  logic [3:0] pending_nibble;
  logic [7:0] line_bytes [MAX_BYTES];
  int lowest_free_addr;
  bit load_aborted;
  logic [15:0] line_no;

  out_item_t expected_results[$];
  logic [7:0] line_text[$];
  plan_row_t plan[$];
  logic [2:0] latest_kind;
  int items_sent = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  int calm_left = 50;
  int stall_left = 0;

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  function automatic string describe(out_item_t r);
    return $sformatf("kind=%0d addr=%03h data=%02h line=%0d last=%0b",
                     r.result_kind, r.address, r.data_byte, r.line_number, r.last);
  endfunction

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'(CH_ZERO);
    if (c >= "a" && c <= "f") return int'(c) - int'(CH_LOWER_A) + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'(CH_UPPER_A) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(v) - 8'd10;
  endfunction

  function automatic void clear_line();
    scan_col = 0;
    line_broken = 1'b0;
    addr_seen = 1'b0;
    data_seen = 1'b0;
    data_done = 1'b0;
    line_base = 0;
    digit_total = 0;
    pending_nibble = '0;
  endfunction

  function automatic void restart_loader();
    clear_line();
    foreach (line_bytes[i]) line_bytes[i] = '0;
    lowest_free_addr = 0;
    load_aborted = 1'b0;
    line_no = 16'd1;
  endfunction

  function automatic void emit_result(logic [2:0] kind, logic [11:0] addr, logic [7:0] data);
    out_item_t r;
    r.result_kind = kind;
    r.address = addr;
    r.data_byte = data;
    r.line_number = line_no;
    r.last = 1'b0;
    expected_results.push_back(r);
    latest_kind = kind;
  endfunction

  function automatic void scan_char(logic [7:0] c);
    int col;
    int h;
    col = scan_col;
    if (col > int'(COL_BAR)) return;
    scan_col = col + 1;
    if (line_broken) return;
    if (col == int'(COL_BAR)) begin
      if (c != CH_BAR || (data_seen && !data_done)) line_broken = 1'b1;
      return;
    end
    if (col == int'(COL_FIRST)) begin
      if (c == CH_ZERO) addr_seen = 1'b1;
      else if (c != CH_SPACE) line_broken = 1'b1;
      return;
    end
    if (!addr_seen) begin
      if (c != CH_SPACE) line_broken = 1'b1;
      return;
    end
    if (col == int'(COL_X)) begin
      if (c != CH_X) line_broken = 1'b1;
      return;
    end
    if (col <= int'(COL_ADDR_LAST)) begin
      h = hex_nibble(c);
      if (h < 0) line_broken = 1'b1;
      else line_base = ((line_base << 4) | h) & 12'hFFF;
      return;
    end
    if (col == int'(COL_COLON)) begin
      if (c != CH_COLON) line_broken = 1'b1;
      return;
    end
    if (col == int'(COL_GAP)) begin
      if (c != CH_SPACE) line_broken = 1'b1;
      return;
    end
    if (col == int'(COL_DATA)) begin
      if (c == CH_SPACE) begin
        data_done = 1'b1;
        return;
      end
      data_seen = 1'b1;
    end
    if (data_done) begin
      if (c != CH_SPACE) line_broken = 1'b1;
      return;
    end
    if (c == CH_SPACE) begin
      data_done = 1'b1;
      if (digit_total % 2 == 1) line_broken = 1'b1;
      return;
    end
    h = hex_nibble(c);
    if (h < 0) begin
      line_broken = 1'b1;
      return;
    end
    digit_total++;
    if (digit_total % 2 == 1) pending_nibble = 4'(h);
    else if (digit_total / 2 - 1 < MAX_BYTES)
      line_bytes[digit_total / 2 - 1] = {pending_nibble, 4'(h)};
  endfunction

  function automatic void close_line(bit at_eof);
    int nbytes;
    bit bad;
    nbytes = digit_total / 2;
    bad = line_broken || scan_col <= int'(COL_BAR);
    if (!bad && data_seen) begin
      if (digit_total % 2 == 1 || nbytes > MAX_BYTES) bad = 1'b1;
      else if (line_base < lowest_free_addr) bad = 1'b1;
      else if (line_base + nbytes > LOAD_MEM_SIZE) bad = 1'b1;
    end
    if (bad) begin
      emit_result(RES_REJECT, '0, '0);
      load_aborted = 1'b1;
    end else begin
      if (data_seen) begin
        for (int i = 0; i < nbytes; i++) emit_result(RES_BYTE, 12'(line_base + i), line_bytes[i]);
        lowest_free_addr = line_base + nbytes;
      end
      if (!at_eof) emit_result(RES_ACCEPT, '0, '0);
      if (line_no != 16'hFFFF) line_no++;
    end
    clear_line();
  endfunction

  function automatic void predict_item(logic [1:0] kind, logic [7:0] code);
    int queued;
    queued = expected_results.size();
    case (kind)
      KIND_CHAR: begin
        if (!load_aborted) scan_char(code);
      end
      KIND_EOL: begin
        if (load_aborted) clear_line();
        else close_line(1'b0);
      end
      KIND_EOF: begin
        if (!load_aborted && scan_col > 0) close_line(1'b1);
        emit_result(load_aborted ? RES_LOAD_FAIL : RES_LOAD_OK, '0, '0);
        restart_loader();
      end
      default: ;
    endcase
    if (expected_results.size() > queued) expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(logic [1:0] kind, logic [7:0] code);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{kind: kind, char_code: code};
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_item(kind, code);
    if (kind != KIND_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_line(logic [1:0] term);
    foreach (line_text[i]) send_item(KIND_CHAR, line_text[i]);
    send_item(term, 8'($urandom_range(0, 255)));
  endtask

  // mostly well-formed address lines just above the lowest free address; some broken
  task automatic random_line(output logic [1:0] term);
    int r;
    int ndig;
    int nbytes;
    int base;
    int pos;
    logic [11:0] base_addr;
    line_text.delete();
    term = KIND_EOL;
    if (load_aborted && $urandom_range(0, 9) < 7) begin
      term = KIND_EOF;
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      term = KIND_EOF;
      return;
    end
    if (r < 14) begin
      repeat (int'(COL_BAR)) line_text.push_back(CH_SPACE);
    end else begin
      ndig = 2 * $urandom_range(0, MAX_BYTES);
      nbytes = ndig / 2;
      if ($urandom_range(0, 9) == 0 || lowest_free_addr + nbytes > LOAD_MEM_SIZE)
        base = $urandom_range(0, LOAD_MEM_SIZE - 1);
      else if ($urandom_range(0, 9) == 0)
        base = $urandom_range(lowest_free_addr, LOAD_MEM_SIZE - nbytes);
      else
        base = lowest_free_addr + $urandom_range(0, 12);
      if (base > LOAD_MEM_SIZE - nbytes) base = LOAD_MEM_SIZE - nbytes;
      base_addr = 12'(base);
      line_text.push_back(CH_ZERO);
      line_text.push_back(CH_X);
      line_text.push_back(hex_char(base_addr[11:8]));
      line_text.push_back(hex_char(base_addr[7:4]));
      line_text.push_back(hex_char(base_addr[3:0]));
      line_text.push_back(CH_COLON);
      line_text.push_back(CH_SPACE);
      if ($urandom_range(0, 19) == 0) ndig++;  // odd digit run
      repeat (ndig) line_text.push_back(hex_char(4'($urandom_range(0, 15))));
      while (line_text.size() < int'(COL_BAR)) line_text.push_back(CH_SPACE);
    end
    line_text.push_back(CH_BAR);
    repeat ($urandom_range(0, 5)) line_text.push_back(8'($urandom_range(0, 255)));
    r = $urandom_range(0, 99);
    pos = $urandom_range(0, line_text.size() - 1);
    if (r < 10) line_text[pos] = 8'($urandom_range(0, 255));
    else if (r < 14) line_text.delete(pos);
    if ($urandom_range(0, 99) < 8) term = KIND_EOF;
  endtask

  // results: compared against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_results.size() == 0) begin
        flag_error({"result with nothing expected: ", describe(out_item)});
      end else begin
        want = expected_results.pop_front();
        if (out_item.result_kind !== want.result_kind || out_item.address !== want.address ||
            out_item.data_byte !== want.data_byte || out_item.line_number !== want.line_number ||
            out_item.last !== want.last)
          flag_error({"expected ", describe(want), " got ", describe(out_item)});
      end
    end
  end

  // quiet stretches with no idling on either side
  always @(negedge clk) begin
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      calm = ($urandom_range(0, 3) == 0);
      calm_left = $urandom_range(20, 200);
    end
  end

  always @(negedge clk) begin
    logic stall_next;
    if (stall_left > 0) begin
      stall_left--;
      stall_next = 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      stall_next = (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end else begin
      stall_next = 1'b0;
    end
    out_stall <= stall_next;
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0] term;
    restart_loader();

    // file with good lines, extremes of address and byte count, unterminated last line
    plan.push_back('{"", FRAME_BAR, "", KIND_EOL, 1'b1, RES_ACCEPT});
    plan.push_back('{"0x000: 00ff5aA5C37e8101fE10", FRAME_BAR, " note~", KIND_EOL, 1'b1,
                     RES_ACCEPT});
    plan.push_back('{"0xfff: ", FRAME_BAR, "", KIND_EOL, 1'b1, RES_ACCEPT});
    plan.push_back('{"0xFF6: 0102030405060708090A", FRAME_BAR, "", KIND_EOL, 1'b1, RES_ACCEPT});
    plan.push_back('{"", FRAME_BAR, "", KIND_EOF, 1'b1, RES_LOAD_OK});
    // address below the previous line's end, then ignored input until end of file
    plan.push_back('{"0x100: 1234", FRAME_BAR, "", KIND_EOL, 1'b0, RES_NONE});
    plan.push_back('{"0x0ff: 56", FRAME_BAR, "", KIND_EOL, 1'b1, RES_REJECT});
    plan.push_back('{"garbage", FRAME_BAR, "", KIND_EOL, 1'b0, RES_NONE});
    plan.push_back('{"", FRAME_NONE, "", KIND_EOF, 1'b1, RES_LOAD_FAIL});
    // line of exactly 28 characters
    plan.push_back('{"", FRAME_PAD, "", KIND_EOL, 1'b1, RES_REJECT});
    plan.push_back('{"", FRAME_NONE, "", KIND_EOF, 1'b1, RES_LOAD_FAIL});
    // odd digit count
    plan.push_back('{"0x200: 123", FRAME_BAR, "", KIND_EOL, 1'b1, RES_REJECT});
    plan.push_back('{"", FRAME_NONE, "", KIND_EOF, 1'b1, RES_LOAD_FAIL});
    // data run up to the bar column
    plan.push_back('{"0x300: 0123456789abcdef01234", FRAME_BAR, "", KIND_EOL, 1'b1, RES_REJECT});
    plan.push_back('{"", FRAME_NONE, "", KIND_EOF, 1'b1, RES_LOAD_FAIL});
    // past the end of memory
    plan.push_back('{"0xFFF: 0102", FRAME_BAR, "", KIND_EOL, 1'b1, RES_REJECT});
    plan.push_back('{"", FRAME_NONE, "", KIND_EOF, 1'b1, RES_LOAD_FAIL});
    // unused kind, upper-case X
    plan.push_back('{"", FRAME_NONE, "", KIND_UNUSED, 1'b0, RES_NONE});
    plan.push_back('{"0X000: ", FRAME_BAR, "", KIND_EOL, 1'b1, RES_REJECT});
    plan.push_back('{"", FRAME_NONE, "", KIND_EOF, 1'b1, RES_LOAD_FAIL});
    // empty file, then a good data line cut short by end of file
    plan.push_back('{"", FRAME_NONE, "", KIND_EOF, 1'b1, RES_LOAD_OK});
    plan.push_back('{"0x020: abcd", FRAME_BAR, "", KIND_EOF, 1'b1, RES_LOAD_OK});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      line_text.delete();
      for (int j = 0; j < plan[i].body.len(); j++) line_text.push_back(plan[i].body[j]);
      if (plan[i].frame != FRAME_NONE)
        while (line_text.size() < int'(COL_BAR)) line_text.push_back(CH_SPACE);
      if (plan[i].frame == FRAME_BAR) begin
        line_text.push_back(CH_BAR);
        for (int j = 0; j < plan[i].note.len(); j++) line_text.push_back(plan[i].note[j]);
      end
      latest_kind = RES_NONE;
      send_line(plan[i].term);
      if (plan[i].typed && latest_kind != plan[i].want)
        flag_error($sformatf("row %0d: final result kind %0d, table says %0d",
                             i, latest_kind, plan[i].want));
    end

    items_sent = 0;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) send_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
      random_line(term);
      send_line(term);
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== object_line_loader.f =====
hdl/oll_pkg.sv
hdl/oll_front.sv
hdl/oll_queue.sv
hdl/oll_back.sv
hdl/object_line_loader.sv
test/tb_top.sv
